[sv/cbfc_pkg.sv]
// ----------------------------------------------------------------------------
// cbfc_pkg
// Shared types, codes and helpers of the freezer cartridge bank controller.
// ----------------------------------------------------------------------------
package cbfc_pkg;

	// Storage sizes
	localparam int RAM_BYTES = 32768;
	localparam int RAM_AW    = $clog2(RAM_BYTES);
	localparam int OFF_W     = 13;

	// Freeze sequence constants
	localparam logic [7:0] WRITES_NEEDED = 8'd3;
	localparam logic [7:0] FREEZE_MARK   = 8'd255;

	// Bus operation codes
	localparam logic [1:0] OP_IO1    = 2'd0;
	localparam logic [1:0] OP_ROML   = 2'd1;
	localparam logic [1:0] OP_CYCEND = 2'd2;
	localparam logic [1:0] OP_FREEZE = 2'd3;

	// Mapping modes
	localparam logic [1:0] MAP_ROM = 2'd0;
	localparam logic [1:0] MAP_RAM = 2'd1;
	localparam logic [1:0] MAP_OFF = 2'd2;

	// IO1 register offsets and window page (0x1e00 in the bank)
	localparam logic [7:0] REG_CTRL = 8'd0;
	localparam logic [7:0] REG_EXT  = 8'd1;
	localparam logic [4:0] IO1_PAGE = 5'b11110;

	// Control byte written when the write run ends: ultimax, ROM bank 0
	localparam logic [7:0] CTRL_FREEZE = 8'h03;
	localparam logic [7:0] STAT_KEEP   = 8'h42;
	localparam logic [7:0] STAT_TAKE   = 8'h98;

	// Control state touched by a control register write
	typedef struct packed {
		logic [2:0] bank;
		logic [1:0] map;
		logic [1:0] ram_bank;
		logic [7:0] status;
		logic       exrom;
		logic       game;
		logic       irq;
		logic       led;
	} ctl_t;

	// One RAM access per item
	typedef struct packed {
		logic              we;
		logic              re;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

	// Result of one item, before the RAM read data joins it
	typedef struct packed {
		logic [7:0]  rdata;
		logic        rvalid;
		logic        from_ram;
		logic        rfetch;
		logic [15:0] raddr;
		logic        exrom;
		logic        game;
		logic        irq;
		logic        led;
	} res_t;

	// Control register write
	function automatic ctl_t apply_ctl(ctl_t s, logic [7:0] d);
		ctl_t r;
		r = s;
		if (d[6]) begin
			r.irq       = 1'b0;
			r.status[2] = 1'b0;
		end
		r.bank = {d[7], d[4], d[3]};
		r.map  = MAP_ROM;
		if (d[5]) begin
			r.map      = MAP_RAM;
			r.ram_bank = {d[4], d[3]};
		end
		r.exrom = ~d[1];
		r.game  = d[0];
		if (d[2]) begin
			r.map = MAP_OFF;
			r.led = 1'b0;
		end
		r.status = (r.status & STAT_KEEP) | (d & STAT_TAKE);
		return r;
	endfunction

endpackage

[sv/cbfc_ram.sv]
// ----------------------------------------------------------------------------
// cbfc_ram
// Cartridge RAM: one access per cycle once the sweep is done, registered read,
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module cbfc_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  cbfc_pkg::ram_req_t req,
	output logic [7:0]         rdata,
	output logic               ready
);
	import cbfc_pkg::*;

	logic [7:0]        mem [RAM_BYTES];
	logic              clr_busy_q;
	logic [RAM_AW-1:0] clr_addr_q;
	logic [7:0]        rdata_q;

	// Zeroing sweep, one byte a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q)
				clr_busy_q <= 1'b0;
		end
	end

	// Storage and registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 8'h00;
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re)
			rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;
	assign ready = ~clr_busy_q;

endmodule

[sv/cbfc_core.sv]
// ----------------------------------------------------------------------------
// cbfc_core
// Control state and per-item decode: banking, mapping, status, freeze
// sequence, RAM request and result.
// ----------------------------------------------------------------------------
module cbfc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [1:0]         op,
	input  logic               is_write,
	input  logic [12:0]        address,
	input  logic [7:0]         write_data,
	output cbfc_pkg::ram_req_t ram_req,
	output cbfc_pkg::res_t     res
);
	import cbfc_pkg::*;

	ctl_t       ctl_q;
	logic       freeze_off_q;
	logic [7:0] cnt_q;

	ctl_t       ctl_n;
	logic       freeze_off_n;
	logic [7:0] cnt_n;
	logic [7:0] off;
	logic [7:0] cnt_dec;

	assign off     = address[7:0];
	assign cnt_dec = cnt_q - 8'd1;

	// Next state and item result
	always_comb begin
		ctl_n        = ctl_q;
		freeze_off_n = freeze_off_q;
		cnt_n        = cnt_q;
		ram_req      = '0;
		res          = '0;
		case (op)
			OP_IO1: begin
				if (ctl_q.map != MAP_OFF) begin
					if (ctl_q.map == MAP_RAM && !ctl_q.status[1])
						ctl_n.ram_bank = 2'd0;
					ram_req.addr  = {ctl_n.ram_bank, IO1_PAGE, off};
					ram_req.wdata = write_data;
					if (is_write) begin
						if (off == REG_CTRL) begin
							ctl_n = apply_ctl(ctl_n, write_data);
						end else if (off == REG_EXT) begin
							if (ctl_q.status == 8'h00) begin
								if (write_data[2])
									freeze_off_n = 1'b1;
								ctl_n.status = write_data & 8'hfb;
							end
						end else if (ctl_q.map == MAP_RAM) begin
							ram_req.we = 1'b1;
						end
					end else begin
						if (off == REG_CTRL || off == REG_EXT) begin
							res.rdata  = ctl_q.status;
							res.rvalid = 1'b1;
						end else if (ctl_q.map == MAP_RAM) begin
							ram_req.re   = 1'b1;
							res.rvalid   = 1'b1;
							res.from_ram = 1'b1;
						end else begin
							res.rfetch = 1'b1;
							res.raddr  = {ctl_q.bank, IO1_PAGE, off};
						end
					end
				end
			end
			OP_ROML: begin
				if (ctl_q.map != MAP_OFF) begin
					ram_req.addr  = {ctl_q.ram_bank, address};
					ram_req.wdata = write_data;
					if (!is_write) begin
						if (ctl_q.map == MAP_RAM) begin
							ram_req.re   = 1'b1;
							res.rvalid   = 1'b1;
							res.from_ram = 1'b1;
						end else begin
							res.rfetch = 1'b1;
							res.raddr  = {ctl_q.bank, address};
						end
					end else if (ctl_q.map == MAP_RAM) begin
						ram_req.we = 1'b1;
					end
				end
			end
			OP_CYCEND: begin
				// Freeze pending waits for a read cycle, then the write run counts
				if (cnt_q != 8'd0) begin
					if (cnt_q == FREEZE_MARK) begin
						ctl_n.status[2] = 1'b1;
						if (!is_write) begin
							ctl_n.irq = 1'b1;
							ctl_n.led = 1'b1;
							cnt_n     = WRITES_NEEDED;
						end
					end else if (!is_write) begin
						cnt_n = WRITES_NEEDED;
					end else begin
						cnt_n = cnt_dec;
						if (cnt_dec == 8'd0)
							ctl_n = apply_ctl(ctl_n, CTRL_FREEZE);
					end
				end
			end
			OP_FREEZE: begin
				if (!freeze_off_q)
					cnt_n = FREEZE_MARK;
			end
			default: begin
			end
		endcase
		if (!fire) begin
			ram_req.we = 1'b0;
			ram_req.re = 1'b0;
		end
		res.exrom = ctl_n.exrom;
		res.game  = ctl_n.game;
		res.irq   = ctl_n.irq;
		res.led   = ctl_n.led;
	end

	// State registers, reset to the power-on control write of zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q        <= '{bank: 3'd0, map: MAP_ROM, ram_bank: 2'd0, status: 8'h00,
				exrom: 1'b1, game: 1'b0, irq: 1'b0, led: 1'b0};
			freeze_off_q <= 1'b0;
			cnt_q        <= 8'd0;
		end else if (fire) begin
			ctl_q        <= ctl_n;
			freeze_off_q <= freeze_off_n;
			cnt_q        <= cnt_n;
		end
	end

	// One RAM port: never a read and a write for the same item
	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("RAM read and write requested together");

	// Interrupt only rises on a cycle end
	a_irq_on_cycend: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !ctl_q.irq && ctl_n.irq |-> op == OP_CYCEND)
		else $error("interrupt raised outside a cycle end");

endmodule

[sv/cartridge_bank_freeze_controller.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_freeze_controller
// Freezer cartridge banking, RAM and freeze sequence on a stream interface.
// ----------------------------------------------------------------------------
// Result path: input register, then result register and registered RAM read.
// Throughput: one item per cycle unless the output stalls; the single RAM
//   port serves one access each.
// Reset: control state returns to ROM bank 0 with EXROM asserted; the RAM is
//   then zeroed one byte a cycle, with no item accepted.
// ----------------------------------------------------------------------------
module cartridge_bank_freeze_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // address[12:0], write_data[20:13], zero fill
	input  logic [2:0]  s_axis_tuser,  // op[1:0], is_write[2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // read_data[7:0], rom_address[23:8],
	                                   // exrom[24], game[25], interrupt[26], led[27]
	output logic [1:0]  m_axis_tuser   // read_valid[0], rom_fetch[1]
);
	import cbfc_pkg::*;

	logic        v_s1;
	logic [1:0]  op_s1;
	logic        wr_s1;
	logic [12:0] addr_s1;
	logic [7:0]  data_s1;

	logic        v_s2;
	res_t        res_s2;

	logic        adv;
	logic        fire;
	logic        ram_ready;
	logic [7:0]  ram_rdata;
	ram_req_t    ram_req;
	res_t        res;
	logic [7:0]  rd_out;

	assign adv           = ~v_s2 | m_axis_tready;
	assign fire          = v_s1 & adv;
	assign s_axis_tready = ram_ready & (adv | ~v_s1);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv || !v_s1) begin
			v_s1 <= s_axis_tvalid & ram_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= s_axis_tuser[1:0];
			wr_s1   <= s_axis_tuser[2];
			addr_s1 <= s_axis_tdata[12:0];
			data_s1 <= s_axis_tdata[20:13];
		end
	end

	cbfc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (op_s1),
		.is_write   (wr_s1),
		.address    (addr_s1),
		.write_data (data_s1),
		.ram_req    (ram_req),
		.res        (res)
	);

	cbfc_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata),
		.ready  (ram_ready)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_s2 <= res;
	end

	assign rd_out        = res_s2.from_ram ? ram_rdata : res_s2.rdata;
	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {4'b0000, res_s2.led, res_s2.irq, res_s2.game, res_s2.exrom,
		res_s2.raddr, rd_out};
	assign m_axis_tuser  = {res_s2.rfetch, res_s2.rvalid};

	// No item enters while the RAM is being zeroed
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!ram_ready |-> !s_axis_tready)
		else $error("item accepted during RAM clear");

	// A result may be a bus read or a ROM fetch, never both
	a_read_or_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("read data and ROM fetch on the same item");

	// ROM address is zero unless a fetch is requested
	a_raddr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[23:8] == 16'h0000)
		else $error("ROM address without fetch");

	// A RAM read result follows an item that fired in the previous cycle
	a_ram_data_timing: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ram_req.re |=> v_s2 && res_s2.from_ram)
		else $error("RAM read lost its result slot");

endmodule
